// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, command and status types of the modular exponentiation
// block over the fixed prime 1000000007.
// ----------------------------------------------------------------------------
package mexp_pkg;

   // field widths
   localparam int unsigned BaseWidth    = 63;
   localparam int unsigned ExpWidth     = 63;
   localparam int unsigned ResidueWidth = 30;

   // shared multiplier operand and product widths
   localparam int unsigned MulWidth  = 31;
   localparam int unsigned ProdWidth = 2 * MulWidth;

   // remainder before final correction stays below three times the prime
   localparam int unsigned RemWidth = 32;

   // base folded into its residue 30 bits at a time below its top bits
   localparam int unsigned BaseTopWidth = BaseWidth - 2 * ResidueWidth;

   // counter over the base reduction steps and the exponent bits
   localparam int unsigned CountWidth = 6;
   localparam logic [CountWidth-1:0] LastReduceStep = CountWidth'(1);
   localparam logic [CountWidth-1:0] LastExpBit     = CountWidth'(ExpWidth - 1);

   // modulus and its multiples
   localparam logic [ResidueWidth-1:0] PrimeMod   = 30'd1000000007;
   localparam logic [RemWidth-1:0]     PrimeMod1x = RemWidth'(PrimeMod);
   localparam logic [RemWidth-1:0]     PrimeMod2x = RemWidth'(2 * 64'(PrimeMod));

   // barrett factor floor(2^60 / p), fits in 31 bits
   localparam logic [63:0]         BarrettWide = (64'd1 << (2 * ResidueWidth)) / 64'(PrimeMod);
   localparam logic [MulWidth-1:0] BarrettM    = BarrettWide[MulWidth-1:0];

   // datapath operations
   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_REDUCE,
      DP_MUL_SQ,
      DP_MUL_BASE,
      DP_BAR1,
      DP_BAR2,
      DP_SUB,
      DP_FIX,
      DP_FIX_BASE,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      shift_exp;
   } dp_cmd_type;

   typedef struct packed {
      logic base_zero;
      logic exp_zero;
      logic exp_bit;
   } dp_status_type;

endpackage

// ===== rtl/mexp_req_if.sv =====
// ----------------------------------------------------------------------------
// mexp_req_if
// Request channel: base and exponent with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_req_if;

   logic                                 valid;
   logic                                 ready;
   logic [mexp_pkg::BaseWidth-1:0]       base;
   logic [mexp_pkg::ExpWidth-1:0]        exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);

endinterface

// ===== rtl/mexp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mexp_rsp_if
// Response channel: residue with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_rsp_if;

   logic                                 valid;
   logic                                 ready;
   logic [mexp_pkg::ResidueWidth-1:0]    residue;

   modport source (output valid, output residue, input ready);
   modport sink   (input valid, input residue, output ready);

endinterface

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, base reduction in two 30-bit barrett steps, one shared
// multiplier and barrett reduction steps, plus the result register.
// ----------------------------------------------------------------------------
module mexp_datapath (
   input  logic                                clock,
   input  mexp_pkg::dp_cmd_type                cmd,
   input  logic [mexp_pkg::BaseWidth-1:0]      req_base,
   input  logic [mexp_pkg::ExpWidth-1:0]       req_exponent,
   output mexp_pkg::dp_status_type             status,
   output logic [mexp_pkg::ResidueWidth-1:0]   residue
);

   logic [mexp_pkg::BaseWidth-1:0]    base_ff;
   logic [mexp_pkg::ExpWidth-1:0]     exp_ff;
   logic [mexp_pkg::ResidueWidth-1:0] breg_ff;
   logic [mexp_pkg::ResidueWidth-1:0] acc_ff;
   logic [mexp_pkg::ProdWidth-1:0]    prod_ff;
   logic [mexp_pkg::RemWidth-1:0]     x_ff;
   logic [mexp_pkg::RemWidth-1:0]     r_ff;
   logic [mexp_pkg::ResidueWidth-1:0] fix_out;
   logic [mexp_pkg::ResidueWidth-1:0] residue_ff;
   logic                              base_zero_ff;
   logic                              exp_zero_ff;

   logic [mexp_pkg::MulWidth-1:0]     mul_a;
   logic [mexp_pkg::MulWidth-1:0]     mul_b;
   logic [mexp_pkg::ProdWidth-1:0]    mul_out;

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         mexp_pkg::DP_MUL_SQ: begin
            mul_a = mexp_pkg::MulWidth'(acc_ff);
            mul_b = mexp_pkg::MulWidth'(acc_ff);
         end
         mexp_pkg::DP_MUL_BASE: begin
            mul_a = mexp_pkg::MulWidth'(acc_ff);
            mul_b = mexp_pkg::MulWidth'(breg_ff);
         end
         mexp_pkg::DP_BAR1: begin
            mul_a = prod_ff[59:29];
            mul_b = mexp_pkg::BarrettM;
         end
         mexp_pkg::DP_BAR2: begin
            mul_a = prod_ff[61:31];
            mul_b = mexp_pkg::MulWidth'(mexp_pkg::PrimeMod);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = {{mexp_pkg::MulWidth{1'b0}}, mul_a} *
                    {{mexp_pkg::MulWidth{1'b0}}, mul_b};

   // final barrett correction, remainder below three times the prime
   always_comb begin
      priority if (r_ff >= mexp_pkg::PrimeMod2x) begin
         fix_out = mexp_pkg::ResidueWidth'(r_ff - mexp_pkg::PrimeMod2x);
      end else if (r_ff >= mexp_pkg::PrimeMod1x) begin
         fix_out = mexp_pkg::ResidueWidth'(r_ff - mexp_pkg::PrimeMod1x);
      end else begin
         fix_out = r_ff[mexp_pkg::ResidueWidth-1:0];
      end
   end

   // operand and intermediate registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mexp_pkg::DP_LOAD: begin
            base_ff      <= req_base;
            exp_ff       <= req_exponent;
            base_zero_ff <= (req_base == '0);
            exp_zero_ff  <= (req_exponent == '0);
            breg_ff      <= mexp_pkg::ResidueWidth'(
                               req_base[mexp_pkg::BaseWidth-1 -: mexp_pkg::BaseTopWidth]);
            acc_ff       <= mexp_pkg::ResidueWidth'(1);
         end
         // running base residue times 2^30 plus the next 30 base bits
         mexp_pkg::DP_REDUCE: begin
            prod_ff <= mexp_pkg::ProdWidth'({breg_ff,
               base_ff[mexp_pkg::BaseWidth-mexp_pkg::BaseTopWidth-1 -: mexp_pkg::ResidueWidth]});
            base_ff <= base_ff << mexp_pkg::ResidueWidth;
         end
         mexp_pkg::DP_MUL_SQ, mexp_pkg::DP_MUL_BASE: begin
            prod_ff <= mul_out;
         end
         mexp_pkg::DP_BAR1: begin
            x_ff    <= prod_ff[mexp_pkg::RemWidth-1:0];
            prod_ff <= mul_out;
         end
         mexp_pkg::DP_BAR2: begin
            prod_ff <= mul_out;
         end
         mexp_pkg::DP_SUB: begin
            r_ff <= x_ff - prod_ff[mexp_pkg::RemWidth-1:0];
         end
         mexp_pkg::DP_FIX: begin
            acc_ff <= fix_out;
            if (cmd.shift_exp) begin
               exp_ff <= {exp_ff[mexp_pkg::ExpWidth-2:0], 1'b0};
            end
         end
         mexp_pkg::DP_FIX_BASE: begin
            breg_ff <= fix_out;
         end
         mexp_pkg::DP_OUT: begin
            residue_ff <= base_zero_ff ? '0 : acc_ff;
         end
         default: begin
         end
      endcase
   end

   // status to the controller
   assign status.base_zero = base_zero_ff;
   assign status.exp_zero  = exp_zero_ff;
   assign status.exp_bit   = exp_ff[mexp_pkg::ExpWidth-1];

   assign residue = residue_ff;

endmodule

// ===== rtl/mexp_controller.sv =====
// ----------------------------------------------------------------------------
// mexp_controller
// Sequencer: unless base or exponent is zero, base reduction in two modular
// steps, then square and optional multiply per exponent bit, each as a
// five-step modular multiply; owns both handshakes.
// ----------------------------------------------------------------------------
module mexp_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  mexp_pkg::dp_status_type  status,
   output mexp_pkg::dp_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_BAR1,
      ST_BAR2,
      ST_SUB,
      ST_FIX,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [mexp_pkg::CountWidth-1:0]    count_ff;
   logic                               mul_phase_ff;
   logic                               reduce_phase_ff;
   logic                               rsp_valid_ff;
   logic                               out_free;
   logic                               last_op;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // after fix: the bit is done unless a multiply by the base follows the square
   assign last_op = mul_phase_ff || !status.exp_bit;

   // command decode
   always_comb begin
      cmd.op        = mexp_pkg::DP_IDLE;
      cmd.shift_exp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = mexp_pkg::DP_LOAD;
            end
         end
         ST_REDUCE: begin
            cmd.op = mexp_pkg::DP_REDUCE;
         end
         ST_MUL: begin
            cmd.op = mul_phase_ff ? mexp_pkg::DP_MUL_BASE : mexp_pkg::DP_MUL_SQ;
         end
         ST_BAR1: begin
            cmd.op = mexp_pkg::DP_BAR1;
         end
         ST_BAR2: begin
            cmd.op = mexp_pkg::DP_BAR2;
         end
         ST_SUB: begin
            cmd.op = mexp_pkg::DP_SUB;
         end
         ST_FIX: begin
            if (reduce_phase_ff) begin
               cmd.op = mexp_pkg::DP_FIX_BASE;
            end else begin
               cmd.op        = mexp_pkg::DP_FIX;
               cmd.shift_exp = last_op;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op = mexp_pkg::DP_OUT;
            end
         end
         default: begin
         end
      endcase
   end

   // state, counters and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         mul_phase_ff    <= 1'b0;
         reduce_phase_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // response valid: set when a result is registered, cleared once taken
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  count_ff        <= '0;
                  reduce_phase_ff <= 1'b1;
                  state_ff        <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (status.base_zero || status.exp_zero) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_BAR1;
               end
            end
            ST_MUL: begin
               state_ff <= ST_BAR1;
            end
            ST_BAR1: begin
               state_ff <= ST_BAR2;
            end
            ST_BAR2: begin
               state_ff <= ST_SUB;
            end
            ST_SUB: begin
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               if (reduce_phase_ff) begin
                  if (count_ff == mexp_pkg::LastReduceStep) begin
                     count_ff        <= '0;
                     reduce_phase_ff <= 1'b0;
                     mul_phase_ff    <= 1'b0;
                     state_ff        <= ST_MUL;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     state_ff <= ST_REDUCE;
                  end
               end else if (!last_op) begin
                  mul_phase_ff <= 1'b1;
                  state_ff     <= ST_MUL;
               end else begin
                  mul_phase_ff <= 1'b0;
                  if (count_ff == mexp_pkg::LastExpBit) begin
                     state_ff <= ST_DONE;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/modular_exponentiation_fixed_prime.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_fixed_prime
// Computes base^exponent mod 1000000007 for 63-bit base and exponent.
// ----------------------------------------------------------------------------
// One request is worked at a time. A zero base answers 0 and a zero exponent
// answers 1, without a modular multiply before the response.
// Otherwise the base is first brought below the prime by two barrett steps of
// 30 bits each, then the exponent is scanned from its top bit down: each of
// its 63 bits costs one modular square and, for a one bit, a modular multiply
// by the base. Every modular multiply runs through the single 31x31
// multiplier as product, two barrett multiplies, subtract and correction.
// The result sits in an output register; the next request is taken while it
// waits there, and its own result waits until the register is free.
// ----------------------------------------------------------------------------
module modular_exponentiation_fixed_prime (
   input  logic       clock,
   input  logic       reset,
   mexp_req_if.sink   req_bus,
   mexp_rsp_if.source rsp_bus
);

   mexp_pkg::dp_cmd_type    dp_cmd;
   mexp_pkg::dp_status_type dp_status;

   // sequencer
   mexp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // arithmetic
   mexp_datapath u_dp (
      .clock        (clock),
      .cmd          (dp_cmd),
      .req_base     (req_bus.base),
      .req_exponent (req_bus.exponent),
      .status       (dp_status),
      .residue      (rsp_bus.residue)
   );

endmodule

// ===== test/tb_modular_exponentiation_fixed_prime.sv =====
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_fixed_prime
// Self-checking bench for the modular exponentiation block. A clocked driver
// feeds base/exponent requests from a queue, and a clocked monitor compares
// each residue with the value computed at request time by square-and-multiply
// modulo 1000000007. Both sides idle at random. There is one long receiver
// hold-off and there are sender pauses that let the block drain.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_fixed_prime;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned Prime = 64'd1000000007;
   localparam int ChunkItems    = 1000;
   localparam int HoldCycles    = 3000;
   localparam int HoldAt        = 200;
   localparam int CalmFrom      = 1200;
   localparam int CalmTo        = 1500;
   localparam int DrainCycles   = 800;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic [mexp_pkg::BaseWidth-1:0] base;
      logic [mexp_pkg::ExpWidth-1:0]  exponent;
   } pow_request_type;

   localparam logic [mexp_pkg::BaseWidth-1:0] AllOnes = {mexp_pkg::BaseWidth{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   // locally held drive values, known from time zero
   logic                              req_valid    = 1'b0;
   logic [mexp_pkg::BaseWidth-1:0]    req_base     = '0;
   logic [mexp_pkg::ExpWidth-1:0]     req_exponent = '0;
   logic                              rsp_ready    = 1'b0;

   mexp_req_if req_bus ();
   mexp_rsp_if rsp_bus ();

   assign req_bus.valid    = req_valid;
   assign req_bus.base     = req_base;
   assign req_bus.exponent = req_exponent;
   assign rsp_bus.ready    = rsp_ready;

   modular_exponentiation_fixed_prime dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pow_request_type                   pending_requests[$];
   logic [mexp_pkg::ResidueWidth-1:0] expected_residues[$];
   pow_request_type                   next_request;
   logic [mexp_pkg::ResidueWidth-1:0] wanted_residue;
   int                                mismatch_count = 0;
   int                                results_seen   = 0;
   int                                idle_cycles    = 0;
   int                                hold_left      = 0;
   bit                                hold_started   = 1'b0;
   bit                                calm;

   assign calm = (results_seen >= CalmFrom) && (results_seen < CalmTo);

   always #5 clock = ~clock;

   // base^exponent mod prime by square-and-multiply from the top bit down
   function automatic logic [mexp_pkg::ResidueWidth-1:0] expected_residue(
      logic [mexp_pkg::BaseWidth-1:0] base, logic [mexp_pkg::ExpWidth-1:0] exponent);
      longint unsigned acc;
      longint unsigned base_mod;
      int              bit_idx;
      if (base == '0) return '0;
      if (exponent == '0) return mexp_pkg::ResidueWidth'(1);
      base_mod = 64'(base) % Prime;
      acc = 64'd1;
      for (bit_idx = mexp_pkg::ExpWidth - 1; bit_idx >= 0; bit_idx--) begin
         acc = (acc * acc) % Prime;
         if (exponent[bit_idx]) acc = (acc * base_mod) % Prime;
      end
      return acc[mexp_pkg::ResidueWidth-1:0];
   endfunction

   function automatic logic [62:0] random_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[62:0];
   endfunction

   // base mix: zero, near the prime, prime multiples, small, full width
   function automatic logic [mexp_pkg::BaseWidth-1:0] random_base();
      int              pick;
      longint unsigned k;
      pick = $urandom_range(99);
      k = 64'($urandom_range(32'hFFFF_FFFF, 1));
      if (pick < 5) return '0;
      else if (pick < 10) return mexp_pkg::BaseWidth'(1);
      else if (pick < 15) return mexp_pkg::BaseWidth'(Prime - 1 + 64'($urandom_range(2)));
      else if (pick < 25) return mexp_pkg::BaseWidth'(k * Prime);
      else if (pick < 35) return mexp_pkg::BaseWidth'(k * Prime + 64'($urandom_range(1000)));
      else if (pick < 50) return mexp_pkg::BaseWidth'($urandom_range(65535, 2));
      else if (pick < 65) return mexp_pkg::BaseWidth'(64'($urandom()) % Prime);
      else if (pick < 70) return AllOnes;
      else return random_word();
   endfunction

   // exponent mix: zero, small, one-hot, fermat exponents, sparse, full width
   function automatic logic [mexp_pkg::ExpWidth-1:0] random_exponent();
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) return '0;
      else if (pick < 20) return mexp_pkg::ExpWidth'($urandom_range(15, 1));
      else if (pick < 30)
         return mexp_pkg::ExpWidth'(1) << $urandom_range(mexp_pkg::ExpWidth - 1);
      else if (pick < 35) return AllOnes;
      else if (pick < 45) return mexp_pkg::ExpWidth'(Prime - 1 - 64'($urandom_range(1)));
      else if (pick < 55) return random_word() & random_word() & random_word();
      else return random_word();
   endfunction

   task automatic add_request(logic [mexp_pkg::BaseWidth-1:0] base,
                              logic [mexp_pkg::ExpWidth-1:0]  exponent);
      pow_request_type r;
      r.base     = base;
      r.exponent = exponent;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // sender pause: wait until every queued request is answered
   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_residues.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_bus.ready) begin
         if (req_valid) begin
            expected_residues.insert(expected_residues.size(),
                                     expected_residue(req_base, req_exponent));
         end
         if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
            next_request = pending_requests.pop_front();
            req_valid    <= 1'b1;
            req_base     <= next_request.base;
            req_exponent <= next_request.exponent;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // residue monitor with random backpressure and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_residues.size() == 0) begin
               $error("residue: expected none, actual %0d", rsp_bus.residue);
               mismatch_count++;
            end else begin
               wanted_residue = expected_residues.pop_front();
               if (rsp_bus.residue !== wanted_residue) begin
                  $error("residue: expected %0d, actual %0d", wanted_residue, rsp_bus.residue);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_started && results_seen == HoldAt) begin
            hold_started <= 1'b1;
            hold_left    <= HoldCycles;
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 25);
         end
      end
   end

   // watchdog on cycles without any accepted request or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners: zero base, zero exponent, prime multiples, extremes
      add_request('0, '0);
      add_request('0, 63'd1);
      add_request('0, AllOnes);
      add_request(63'd1, '0);
      add_request(AllOnes, '0);
      add_request(mexp_pkg::BaseWidth'(Prime), '0);
      add_request(mexp_pkg::BaseWidth'(Prime), 63'd7);
      add_request(mexp_pkg::BaseWidth'(Prime * 64'd1234567), AllOnes);
      add_request(63'd1, AllOnes);
      add_request(63'd2, 63'd1);
      add_request(63'd2, 63'd62);
      add_request(63'd2, mexp_pkg::ExpWidth'(Prime - 1));
      add_request(mexp_pkg::BaseWidth'(Prime - 1), 63'd2);
      add_request(mexp_pkg::BaseWidth'(Prime - 1), AllOnes);
      add_request(AllOnes, AllOnes);
      add_request(AllOnes, 63'd1);
      add_request(mexp_pkg::BaseWidth'(Prime + 1), AllOnes);
      add_request(63'd3, mexp_pkg::ExpWidth'(Prime - 2));
      add_request(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
      add_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
      add_request(63'd1 << 62, 63'd1 << 62);
      add_request(63'd12345, 63'd1);
      drain();

      // random requests in two chunks with a full pause between them
      for (n = 0; n < ChunkItems; n++) add_request(random_base(), random_exponent());
      drain();
      for (n = 0; n < ChunkItems; n++) add_request(random_base(), random_exponent());
      drain();

      // catch any stray result after the last expected one
      repeat (DrainCycles) @(posedge clock);
      if (expected_residues.size() != 0) begin
         $error("residue: %0d expected results never arrived", expected_residues.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
